// ===== design/cell_point_gradient_accumulator_unit_assert.svh =====
// Assertion macros for the gradient accumulator.
`ifndef CELL_POINT_GRADIENT_ACCUMULATOR_UNIT_ASSERT_SVH
`define CELL_POINT_GRADIENT_ACCUMULATOR_UNIT_ASSERT_SVH

// Checked outside reset only.
`define CPGA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPGA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cpga_pkg.sv =====
package cpga_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 10;
  localparam int ACC_W    = 48;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;

  localparam int MAX_POINTS_DEF = 1024;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_CORNER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Mode register values
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One point store entry
  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] sum_z;
    logic signed [ACC_W-1:0] sum_y;
    logic signed [ACC_W-1:0] sum_x;
  } cpga_entry_t;

  // Saturating add; result is {overflow, sum}
  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                             input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return {1'b1, (s[ACC_W] ? ACC_MIN : ACC_MAX)};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

endpackage

// ===== design/cell_point_gradient_accumulator_unit.sv =====
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------------------
// input   | in_valid/in_ready   | kind, scalar, weight_x/y/z, point_index, cell_last
// result  | out_valid/out_ready | gradient_x/y/z, overflowed
// config  | cfg_wr_en           | cfg_wr_data (mode)
//
// One transaction per cycle while in_ready is high; a result passes through the input register,
// then the product and store-read register, then the result register.
// A clear transaction holds in_ready low while the point store is swept to zero,
// one entry per cycle through the store's single write port.
// After reset the same sweep runs before the first transaction.
// Outside the clearing sweep, the pipeline stalls only when a result is due while the result
// register is full and out_ready is low.
`include "cell_point_gradient_accumulator_unit_assert.svh"

module cell_point_gradient_accumulator_unit
  import cpga_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_scalar,
  input  logic signed [DATA_W-1:0] in_weight_x,
  input  logic signed [DATA_W-1:0] in_weight_y,
  input  logic signed [DATA_W-1:0] in_weight_z,
  input  logic [IDX_W-1:0]         in_point_index,
  input  logic                     in_cell_last,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACC_W-1:0]  out_gradient_x,
  output logic signed [ACC_W-1:0]  out_gradient_y,
  output logic signed [ACC_W-1:0]  out_gradient_z,
  output logic                     out_overflowed
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_POINTS - 1);

  // Config
  logic cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r <= MODE_CELL;
    end else if (cfg_wr_en) begin
      cfg_mode_r <= cfg_wr_data;
    end
  end

  // Pipeline control
  logic advance;
  logic stall;
  logic s2_emit;
  logic clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Stage 1: input register
  logic                     s1_valid_r;
  logic [KIND_W-1:0]        s1_kind_r;
  logic signed [DATA_W-1:0] s1_scalar_r;
  logic signed [DATA_W-1:0] s1_weight_x_r;
  logic signed [DATA_W-1:0] s1_weight_y_r;
  logic signed [DATA_W-1:0] s1_weight_z_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s1_last_r;

  // Stage 2: products and store entry
  logic                     s2_valid_r;
  logic [KIND_W-1:0]        s2_kind_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic                     s2_last_r;
  logic                     s2_in_range_r;
  logic signed [ACC_W-1:0]  s2_prod_x_r;
  logic signed [ACC_W-1:0]  s2_prod_y_r;
  logic signed [ACC_W-1:0]  s2_prod_z_r;
  cpga_entry_t              rd_entry_r;
  logic                     fwd_hit_r;
  cpga_entry_t              fwd_entry_r;

  // Running cell sum
  logic signed [ACC_W-1:0]  run_x_r;
  logic signed [ACC_W-1:0]  run_y_r;
  logic signed [ACC_W-1:0]  run_z_r;
  logic                     run_ovf_r;

  // Result register
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  out_x_r;
  logic signed [ACC_W-1:0]  out_y_r;
  logic signed [ACC_W-1:0]  out_z_r;
  logic                     out_ovf_r;

  assign stall    = s2_emit && out_valid_r && !out_ready;
  assign advance  = !stall && !clr_busy_r;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind_r     <= in_kind;
      s1_scalar_r   <= in_scalar;
      s1_weight_x_r <= in_weight_x;
      s1_weight_y_r <= in_weight_y;
      s1_weight_z_r <= in_weight_z;
      s1_idx_r      <= in_point_index;
      s1_last_r     <= in_cell_last;
    end
  end

  // Stage 1 logic: Q16.16 x Q16.16, floor to Q32.16
  logic signed [PROD_W-1:0] p_x;
  logic signed [PROD_W-1:0] p_y;
  logic signed [PROD_W-1:0] p_z;
  logic [ADDR_W-1:0]        s1_addr;
  logic                     s1_in_range;

  assign p_x         = s1_scalar_r * s1_weight_x_r;
  assign p_y         = s1_scalar_r * s1_weight_y_r;
  assign p_z         = s1_scalar_r * s1_weight_z_r;
  assign s1_addr     = ADDR_W'(s1_idx_r);
  assign s1_in_range = 32'(s1_idx_r) < 32'(MAX_POINTS);

  // Stage 2 logic
  cpga_entry_t       entry_old;
  cpga_entry_t       entry_new;
  logic [ACC_W:0]    st_x;
  logic [ACC_W:0]    st_y;
  logic [ACC_W:0]    st_z;
  logic [ACC_W:0]    rn_x;
  logic [ACC_W:0]    rn_y;
  logic [ACC_W:0]    rn_z;
  logic [ADDR_W-1:0] s2_addr;
  logic              s2_go;
  logic              s2_corner;
  logic              s2_cell_go;
  logic              s2_store_we;
  logic              s2_clear_go;
  logic              s2_emit_go;

  assign entry_old = fwd_hit_r ? fwd_entry_r : rd_entry_r;
  assign s2_addr   = ADDR_W'(s2_idx_r);

  assign st_x = sat_add(entry_old.sum_x, s2_prod_x_r);
  assign st_y = sat_add(entry_old.sum_y, s2_prod_y_r);
  assign st_z = sat_add(entry_old.sum_z, s2_prod_z_r);
  assign entry_new.sum_x = st_x[ACC_W-1:0];
  assign entry_new.sum_y = st_y[ACC_W-1:0];
  assign entry_new.sum_z = st_z[ACC_W-1:0];
  assign entry_new.ovf   = entry_old.ovf | st_x[ACC_W] | st_y[ACC_W] | st_z[ACC_W];

  assign rn_x = sat_add(run_x_r, s2_prod_x_r);
  assign rn_y = sat_add(run_y_r, s2_prod_y_r);
  assign rn_z = sat_add(run_z_r, s2_prod_z_r);

  assign s2_go       = advance && s2_valid_r;
  assign s2_corner   = s2_kind_r == KIND_CORNER;
  assign s2_cell_go  = s2_go && s2_corner && (cfg_mode_r == MODE_CELL);
  assign s2_store_we = s2_go && s2_corner && (cfg_mode_r == MODE_POINT) && s2_in_range_r;
  assign s2_clear_go = s2_go && (s2_kind_r == KIND_CLEAR);
  assign s2_emit     = s2_valid_r &&
                       ((s2_kind_r == KIND_READ) ||
                        (s2_corner && (cfg_mode_r == MODE_CELL) && s2_last_r));
  assign s2_emit_go  = advance && s2_emit;

  // Forwarding for a store entry read while the stage ahead rewrites it
  logic        fwd_hit_nxt;
  cpga_entry_t fwd_entry_nxt;

  assign fwd_hit_nxt   = s2_clear_go || (s2_store_we && (s2_addr == s1_addr));
  assign fwd_entry_nxt = s2_clear_go ? cpga_entry_t'('0) : entry_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_kind_r     <= s1_kind_r;
      s2_idx_r      <= s1_idx_r;
      s2_last_r     <= s1_last_r;
      s2_in_range_r <= s1_in_range;
      s2_prod_x_r   <= p_x[PROD_W-1:FRAC_W];
      s2_prod_y_r   <= p_y[PROD_W-1:FRAC_W];
      s2_prod_z_r   <= p_z[PROD_W-1:FRAC_W];
      fwd_hit_r     <= fwd_hit_nxt;
      fwd_entry_r   <= fwd_entry_nxt;
    end
  end

  // Point store: one write port shared with the clearing sweep, one registered read
  cpga_entry_t       point_mem [MAX_POINTS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cpga_entry_t       mem_wdata;

  assign mem_we    = clr_busy_r || s2_store_we;
  assign mem_waddr = clr_busy_r ? clr_cnt_r : s2_addr;
  assign mem_wdata = clr_busy_r ? cpga_entry_t'('0) : entry_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      point_mem[mem_waddr] <= mem_wdata;
    end
    if (advance) begin
      rd_entry_r <= point_mem[s1_addr];
    end
  end

  // Clearing sweep after reset and after each clear transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end else if (s2_clear_go) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end
  end

  // Running cell sum, cleared when the cell's result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_x_r   <= '0;
      run_y_r   <= '0;
      run_z_r   <= '0;
      run_ovf_r <= 1'b0;
    end else if (s2_cell_go) begin
      if (s2_last_r) begin
        run_x_r   <= '0;
        run_y_r   <= '0;
        run_z_r   <= '0;
        run_ovf_r <= 1'b0;
      end else begin
        run_x_r   <= rn_x[ACC_W-1:0];
        run_y_r   <= rn_y[ACC_W-1:0];
        run_z_r   <= rn_z[ACC_W-1:0];
        run_ovf_r <= run_ovf_r | rn_x[ACC_W] | rn_y[ACC_W] | rn_z[ACC_W];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit_go) begin
      if (s2_kind_r == KIND_READ) begin
        if (s2_in_range_r) begin
          out_x_r   <= entry_old.sum_x;
          out_y_r   <= entry_old.sum_y;
          out_z_r   <= entry_old.sum_z;
          out_ovf_r <= entry_old.ovf;
        end else begin
          out_x_r   <= '0;
          out_y_r   <= '0;
          out_z_r   <= '0;
          out_ovf_r <= 1'b0;
        end
      end else begin
        out_x_r   <= rn_x[ACC_W-1:0];
        out_y_r   <= rn_y[ACC_W-1:0];
        out_z_r   <= rn_z[ACC_W-1:0];
        out_ovf_r <= run_ovf_r | rn_x[ACC_W] | rn_y[ACC_W] | rn_z[ACC_W];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gradient_x = out_x_r;
  assign out_gradient_y = out_y_r;
  assign out_gradient_z = out_z_r;
  assign out_overflowed = out_ovf_r;

  // Checks
  `CPGA_ASSERT_ALWAYS(a_reset_starts_sweep, !rst_n |=> (clr_busy_r && (clr_cnt_r == '0)), "reset did not start the store sweep")
  `CPGA_ASSERT(a_clear_starts_sweep, s2_clear_go |=> clr_busy_r, "clear transaction did not start the store sweep")
  `CPGA_ASSERT(a_cell_end_clears_sum, (s2_cell_go && s2_last_r) |=> ((run_x_r == '0) && (run_y_r == '0) && (run_z_r == '0) && !run_ovf_r), "running sum not cleared after cell result")
  `CPGA_ASSERT(a_result_has_source, $rose(out_valid_r) |-> $past(s2_emit_go), "result appeared without a source transaction")

endmodule
